FILE: hw/rtl/signed_integer_to_radix_text_top_macros.svh
// assertion macros shared by the converter
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_TOP_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SITRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sitrt_pkg.sv
`timescale 1ns / 1ps

package sitrt_pkg;

	// field and register widths
	localparam int RADIX_W = 6;
	localparam int MAXC_W  = 7;
	localparam int CFG_W   = 7;
	localparam int CHAR_W  = 7;
	localparam int DIGIT_W = 6;

	// register reset values and radix bounds
	localparam logic [RADIX_W-1:0] RADIX_RESET     = 6'd10;
	localparam logic [MAXC_W-1:0]  MAX_CHARS_RESET = 7'd64;
	localparam logic [RADIX_W-1:0] RADIX_MIN       = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_LIMIT     = 6'("Z" - "A" + 1 + 10);

	// ascii codes
	localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'd45;
	localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'd48;
	localparam logic [CHAR_W-1:0] ALPHA_CHAR = 7'd65;
	localparam logic [CHAR_W-1:0] NO_CHAR    = 7'd0;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_RADIX     = 1'b0,
		REG_MAX_CHARS = 1'b1
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_READ,
		ST_EMIT
	} state_t;

	// digit value to its ascii character
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d < 6'd10) begin
			return ZERO_CHAR + dx;
		end
		return ALPHA_CHAR + dx - 7'd10;
	endfunction

endpackage

FILE: hw/rtl/sitrt_ram.sv
`timescale 1ns / 1ps

module sitrt_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/signed_integer_to_radix_text_top.sv
`timescale 1ns / 1ps
// channel   signals                               handshake
// config    wr_en, wr_index, wr_data              write at edge with wr_en high
// request   start, number_in / busy               taken at edge with start & !busy
// result    strobe, text_char, last_char, no_room strobe high for a single cycle per result, no stall
//
// A bit-serial restoring divider yields one quotient bit per cycle and
// walks all VALUE_BITS bits of the value for each digit.
// Results leave through registers while the digit memory is read back,
// one character per read; the receiver cannot stall them.
// arst_n clears the sequencer, counters, result strobe and config registers (radix 10, 64 chars).

`include "signed_integer_to_radix_text_top_macros.svh"

module signed_integer_to_radix_text_top #(
	parameter int MAX_TEXT_LEN = 64,
	parameter int VALUE_BITS   = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [0:0]                        wr_index,
	input  logic [sitrt_pkg::CFG_W-1:0]       wr_data,
	input  logic                              start,
	input  logic signed [VALUE_BITS-1:0]      number_in,
	output logic                              busy,
	output logic                              strobe,
	output logic [sitrt_pkg::CHAR_W-1:0]      text_char,
	output logic                              last_char,
	output logic                              no_room
);

	import sitrt_pkg::*;

	localparam int ADDR_W = $clog2(VALUE_BITS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int CMP_W  = (CNT_W + 1 > MAXC_W) ? CNT_W + 1 : MAXC_W;

	state_t state_q, state_d;

	logic [RADIX_W-1:0]    radix_q;
	logic [MAXC_W-1:0]     max_chars_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [ADDR_W-1:0]     bit_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ADDR_W-1:0]     idx_q;
	logic                  neg_q;
	logic                  strobe_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;
	logic                  room_q;

	logic [RADIX_W-1:0]    base;
	logic [MAXC_W-1:0]     limit;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [DIGIT_W:0]      rem_shift;
	logic                  q_bit;
	logic [DIGIT_W-1:0]    rem_next;
	logic [VALUE_BITS-1:0] quo_next;
	logic                  bit_last;
	logic [CMP_W-1:0]      total;
	logic                  over_limit;
	logic                  ram_we;
	logic                  ram_re;
	logic [DIGIT_W-1:0]    ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			max_chars_q <= MAX_CHARS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_RADIX:     radix_q     <= wr_data[RADIX_W-1:0];
				REG_MAX_CHARS: max_chars_q <= wr_data[MAXC_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated base and length limit
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_LIMIT) begin
			base = RADIX_LIMIT;
		end else begin
			base = radix_q;
		end
		if (max_chars_q > MAXC_W'(MAX_TEXT_LEN)) begin
			limit = MAXC_W'(MAX_TEXT_LEN);
		end else begin
			limit = max_chars_q;
		end
	end

	// magnitude of the request value
	assign raw = number_in;
	assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

	// one restoring division step per cycle
	assign rem_shift = {rem_q, val_q[VALUE_BITS-1]};
	assign q_bit     = rem_shift >= {1'b0, base};
	assign rem_next  = q_bit ? DIGIT_W'(rem_shift - {1'b0, base}) : rem_shift[DIGIT_W-1:0];
	assign quo_next  = {val_q[VALUE_BITS-2:0], q_bit};
	assign bit_last  = bit_q == ADDR_W'(VALUE_BITS - 1);

	// text length check, sign included
	assign total      = CMP_W'(cnt_q) + CMP_W'(neg_q);
	assign over_limit = total > CMP_W'(limit);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory strobes
	always_comb begin
		state_d = state_q;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_last) begin
					ram_we = 1'b1;
					if (quo_next == '0) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				state_d = over_limit ? ST_IDLE : ST_READ;
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = (idx_q == '0) ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q    <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						bit_q <= '0;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					bit_q <= bit_last ? '0 : bit_q + 1'b1;
					if (bit_last) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CHECK: strobe_q <= over_limit || neg_q;
				ST_EMIT:  strobe_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// divider data and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					val_q <= mag;
					neg_q <= raw[VALUE_BITS-1];
					rem_q <= '0;
				end
			end
			ST_DIV: begin
				val_q <= quo_next;
				rem_q <= bit_last ? '0 : rem_next;
			end
			ST_CHECK: begin
				idx_q  <= ADDR_W'(cnt_q - 1'b1);
				char_q <= over_limit ? NO_CHAR : MINUS_CHAR;
				last_q <= over_limit;
				room_q <= over_limit;
			end
			ST_EMIT: begin
				idx_q  <= idx_q - 1'b1;
				char_q <= digit_to_char(ram_rdata);
				last_q <= idx_q == '0;
				room_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// digit store, least significant digit at index zero
	sitrt_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (rem_next),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign busy      = state_q != ST_IDLE;
	assign strobe    = strobe_q;
	assign text_char = char_q;
	assign last_char = last_q;
	assign no_room   = room_q;

	// checks
	`SITRT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request taken but block idle")
	`SITRT_ASSERT_NOW(a_more_follow, strobe && !last_char, busy, "run ended before last char")
	`SITRT_ASSERT_NOW(a_err_sole, strobe && no_room, last_char && text_char == NO_CHAR, "bad error result")
	`SITRT_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(VALUE_BITS), "digit count overflow")

endmodule
